/* rtl/core/mtes_pkg.sv */
// mtes_pkg: shared types and constants for the multi-timer event scheduler
// used by mtes_sched and multi_timer_event_scheduler_core; no dependencies
package mtes_pkg;

   // countdown constants
   localparam logic [31:0] FAR_SENTINEL = 32'h7FFF_FFFF;
   localparam logic [31:0] MOST_NEG     = 32'h8000_0000;
   localparam logic [31:0] ONE          = 32'h0000_0001;

   // request kinds
   localparam logic [1:0] REQ_ARM     = 2'd0;
   localparam logic [1:0] REQ_REARM   = 2'd1;
   localparam logic [1:0] REQ_ADVANCE = 2'd2;

   // timer slots
   localparam int TMR_COMPARE = 0;
   localparam int TMR_SI      = 1;
   localparam int TMR_PI      = 2;
   localparam int TMR_VI      = 3;
   localparam int TMR_RSP     = 4;

   // fired source codes
   localparam logic [2:0] FIRED_NONE    = 3'd0;
   localparam logic [2:0] FIRED_COMPARE = 3'd1;
   localparam logic [2:0] FIRED_VI      = 3'd4;
   localparam logic [2:0] FIRED_LAST    = 3'd5;

   // check pass limit: third pass does no follow-up
   localparam logic [1:0] LAST_PASS = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRE,
      ST_UP,
      ST_DOWN,
      ST_POST
   } state_type;

   // finished transaction handed to the output register
   typedef struct packed {
      logic        valid;
      logic [2:0]  soonest_timer;
      logic [31:0] countdown;
      logic        none_active;
      logic [2:0]  fired_source;
   } rsp_type;

   // compare timer reload value from compare minus count
   function automatic logic [31:0] rearm_value(input logic [31:0] diff);
      logic [31:0] v;
      if (diff[31]) begin
         v = FAR_SENTINEL;
      end else if (diff == 32'd0) begin
         v = ONE;
      end else begin
         v = diff;
      end
      return v;
   endfunction

endpackage

/* rtl/core/mtes_ram.sv */
// mtes_ram: generic single-clock ram, one write and one registered read port
// no dependencies
module mtes_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 5,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/mtes_sched.sv */
// mtes_sched: request sequencer and offset sweep datapath of the scheduler
// depends on mtes_pkg; drives the offset ram held in the top level
module mtes_sched #(
   parameter int NUM_TIMERS = 5,
   localparam int IDX_W = $clog2(NUM_TIMERS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [2:0]         req_timer_index,
   input  logic [30:0]        req_arm_value,
   input  logic [31:0]        req_compare_reg,
   input  logic [31:0]        req_count_reg,
   input  logic [15:0]        req_cycles,
   output logic               ram_wr_en,
   output logic [IDX_W-1:0]   ram_wr_addr,
   output logic [31:0]        ram_wr_data,
   output logic               ram_rd_en,
   output logic [IDX_W-1:0]   ram_rd_addr,
   input  logic [31:0]        ram_rd_data,
   output mtes_pkg::rsp_type  done
);

   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_TIMERS);

   mtes_pkg::state_type state_ff, state_in;
   logic [31:0]            sc_ff, sc_in;
   logic                   sel_valid_ff, sel_valid_in;
   logic [IDX_W-1:0]       sel_idx_ff, sel_idx_in;
   logic [NUM_TIMERS-1:0]  armed_ff, armed_in;
   logic [CNT_W-1:0]       step_ff, step_in;
   logic [1:0]             pass_ff, pass_in;
   logic                   final_ff, final_in;
   logic [31:0]            diff_ff, diff_in;
   logic [31:0]            off0_ff, off0_in;
   logic [31:0]            min_ff, min_in;
   logic                   minv_ff, minv_in;
   logic [IDX_W-1:0]       mini_ff, mini_in;
   logic [2:0]             fired_ff, fired_in;
   logic                   finish;

   // request decode
   logic             accept;
   logic [31:0]      req_diff;
   logic [IDX_W+2:0] req_idx_ext;
   logic [IDX_W-1:0] req_idx;
   logic             req_idx_ok;
   logic [32:0]      adv_wide;
   logic [31:0]      adv;
   logic             adv_pos;

   assign accept      = start && (state_ff == mtes_pkg::ST_IDLE);
   assign busy        = (state_ff != mtes_pkg::ST_IDLE);
   assign req_diff    = req_compare_reg - req_count_reg;
   assign req_idx_ext = {{IDX_W{1'b0}}, req_timer_index};
   assign req_idx     = req_idx_ext[IDX_W-1:0];
   assign req_idx_ok  = ({29'd0, req_timer_index} < 32'(NUM_TIMERS));

   // saturating countdown step
   assign adv_wide = {sc_ff[31], sc_ff} - {17'd0, req_cycles};
   assign adv      = (adv_wide[32] != adv_wide[31]) ? mtes_pkg::MOST_NEG : adv_wide[31:0];
   assign adv_pos  = !adv[31] && (adv != 32'd0);

   // sweep entry currently returned by the ram
   logic [CNT_W-1:0] ent;
   logic [IDX_W-1:0] ent_idx;
   logic             ent_armed;
   logic             ent_skip;
   logic [31:0]      q_up;
   logic [31:0]      q_dn;
   logic [31:0]      up_val;

   assign ent       = step_ff - CNT_W'(1);
   assign ent_idx   = ent[IDX_W-1:0];
   assign ent_armed = armed_ff[ent_idx];
   assign ent_skip  = (32'(ent_idx) == mtes_pkg::TMR_COMPARE)
                      && (ram_rd_data == mtes_pkg::FAR_SENTINEL);
   assign q_up      = ram_rd_data + sc_ff;
   assign q_dn      = ram_rd_data - sc_ff;
   assign up_val    = ent_skip ? ram_rd_data : q_up;

   // firing timer kind
   logic [31:0]      who32;
   logic [IDX_W+2:0] who_ext;

   assign who32   = 32'(sel_idx_ff);
   assign who_ext = {3'b000, sel_idx_ff};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtes_pkg::ST_IDLE;
         sc_ff        <= mtes_pkg::FAR_SENTINEL;
         sel_valid_ff <= 1'b0;
         armed_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         sel_valid_ff <= sel_valid_in;
         armed_ff     <= armed_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      sel_idx_ff <= sel_idx_in;
      step_ff    <= step_in;
      pass_ff    <= pass_in;
      final_ff   <= final_in;
      diff_ff    <= diff_in;
      off0_ff    <= off0_in;
      min_ff     <= min_in;
      minv_ff    <= minv_in;
      mini_ff    <= mini_in;
      fired_ff   <= fired_in;
   end

   // next state and ram control
   always_comb begin
      state_in     = state_ff;
      sc_in        = sc_ff;
      sel_valid_in = sel_valid_ff;
      sel_idx_in   = sel_idx_ff;
      armed_in     = armed_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      final_in     = final_ff;
      diff_in      = diff_ff;
      off0_in      = off0_ff;
      min_in       = min_ff;
      minv_in      = minv_ff;
      mini_in      = mini_ff;
      fired_in     = fired_ff;
      finish       = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      case (state_ff)
         mtes_pkg::ST_IDLE: begin
            if (accept) begin
               fired_in = mtes_pkg::FIRED_NONE;
               diff_in  = req_diff;
               pass_in  = 2'd0;
               final_in = 1'b0;
               step_in  = '0;
               case (req_type)
                  mtes_pkg::REQ_ARM: begin
                     if (!req_idx_ok) begin
                        finish = 1'b1;
                     end else if (req_arm_value == 31'd0) begin
                        armed_in[req_idx] = 1'b0;
                        finish            = 1'b1;
                     end else begin
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = req_idx;
                        ram_wr_data       = {1'b0, req_arm_value} - sc_ff;
                        armed_in[req_idx] = 1'b1;
                        state_in          = mtes_pkg::ST_UP;
                     end
                  end
                  mtes_pkg::REQ_REARM: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = IDX_W'(mtes_pkg::TMR_COMPARE);
                     ram_wr_data = mtes_pkg::rearm_value(req_diff) - sc_ff;
                     armed_in[mtes_pkg::TMR_COMPARE] = 1'b1;
                     state_in    = mtes_pkg::ST_UP;
                  end
                  mtes_pkg::REQ_ADVANCE: begin
                     sc_in = adv;
                     if (adv_pos) begin
                        finish = 1'b1;
                     end else begin
                        state_in = mtes_pkg::ST_FIRE;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end

         // countdown expired: retire, reload or keep the selected timer
         mtes_pkg::ST_FIRE: begin
            step_in  = '0;
            pass_in  = 2'd0;
            final_in = 1'b0;
            state_in = mtes_pkg::ST_UP;
            if (sel_valid_ff && who32 == mtes_pkg::TMR_COMPARE) begin
               fired_in    = mtes_pkg::FIRED_COMPARE;
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDX_W'(mtes_pkg::TMR_COMPARE);
               ram_wr_data = mtes_pkg::rearm_value(diff_ff) - sc_ff;
               armed_in[mtes_pkg::TMR_COMPARE] = 1'b1;
               final_in    = 1'b1;
            end else if (sel_valid_ff && (who32 == mtes_pkg::TMR_SI
                         || who32 == mtes_pkg::TMR_PI || who32 == mtes_pkg::TMR_RSP)) begin
               fired_in             = who_ext[2:0] + 3'd1;
               armed_in[sel_idx_ff] = 1'b0;
            end else if (sel_valid_ff && who32 == mtes_pkg::TMR_VI) begin
               fired_in = mtes_pkg::FIRED_VI;
            end else begin
               fired_in = mtes_pkg::FIRED_NONE;
            end
         end

         // first sweep: rebase up by the countdown and track the minimum
         mtes_pkg::ST_UP: begin
            if (step_ff != LAST_STEP) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = step_ff[IDX_W-1:0];
            end
            if (step_ff == '0) begin
               min_in  = mtes_pkg::FAR_SENTINEL;
               minv_in = 1'b0;
               mini_in = '0;
            end else begin
               if (ent_armed && !ent_skip) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = ent_idx;
                  ram_wr_data = q_up;
               end
               if (ent_armed && ($signed(up_val) < $signed(min_ff))) begin
                  min_in  = up_val;
                  minv_in = 1'b1;
                  mini_in = ent_idx;
               end
            end
            if (step_ff == LAST_STEP) begin
               sc_in        = min_in;
               sel_valid_in = minv_in;
               sel_idx_in   = mini_in;
               step_in      = '0;
               state_in     = mtes_pkg::ST_DOWN;
            end else begin
               step_in = step_ff + CNT_W'(1);
            end
         end

         // second sweep: rebase down by the new countdown
         mtes_pkg::ST_DOWN: begin
            if (step_ff != LAST_STEP) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = step_ff[IDX_W-1:0];
            end
            if (step_ff != '0) begin
               if (ent_armed && !ent_skip) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = ent_idx;
                  ram_wr_data = q_dn;
               end
               if (32'(ent_idx) == mtes_pkg::TMR_COMPARE) begin
                  off0_in = !ent_armed ? 32'd0 : (ent_skip ? ram_rd_data : q_dn);
               end
            end
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = mtes_pkg::ST_POST;
            end else begin
               step_in = step_ff + CNT_W'(1);
            end
         end

         // far sentinel follow-up, then the pending final check or the result
         mtes_pkg::ST_POST: begin
            step_in = '0;
            if (off0_ff != mtes_pkg::FAR_SENTINEL || diff_ff[31]
                || diff_ff == mtes_pkg::FAR_SENTINEL || pass_ff == mtes_pkg::LAST_PASS) begin
               if (final_ff) begin
                  final_in = 1'b0;
                  pass_in  = 2'd0;
                  state_in = mtes_pkg::ST_UP;
               end else begin
                  finish   = 1'b1;
                  state_in = mtes_pkg::ST_IDLE;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = IDX_W'(mtes_pkg::TMR_COMPARE);
               ram_wr_data = mtes_pkg::rearm_value(diff_ff) - sc_ff;
               armed_in[mtes_pkg::TMR_COMPARE] = 1'b1;
               pass_in     = pass_ff + 2'd1;
               state_in    = mtes_pkg::ST_UP;
            end
         end

         default: begin
            state_in = mtes_pkg::ST_IDLE;
         end
      endcase
   end

   // finished transaction, built from the values being committed
   logic [IDX_W+2:0] soon_ext;

   assign soon_ext           = {3'b000, sel_idx_in};
   assign done.valid         = finish;
   assign done.soonest_timer = sel_valid_in ? soon_ext[2:0] : 3'd0;
   assign done.countdown     = sc_in;
   assign done.none_active   = !sel_valid_in;
   assign done.fired_source  = fired_in;

endmodule

/* rtl/core/multi_timer_event_scheduler_core.sv */
// multi_timer_event_scheduler_core: top level of the next-event timer scheduler
// depends on mtes_pkg, mtes_ram and mtes_sched
//
//   channel   handshake            payload
//   request   start / busy         req_type, req_timer_index, req_arm_value,
//                                  req_compare_reg, req_count_reg, req_cycles
//   response  rsp_strobe (1 cycle) rsp_soonest_timer, rsp_countdown,
//                                  rsp_none_active, rsp_fired_source
//
// a transaction is taken when start is high and busy is low; one response
// follows every transaction, the cycle after it finishes
// disarm, ignored and non-expiring advance requests: response the cycle after they are taken
// each check is up to three passes, each an up sweep, a down sweep and a post
// step over the one offset ram port pair; an arm or re-arm runs one check, an
// expired compare timer two
// reset is synchronous and leaves no timer armed with the countdown at 0x7FFFFFFF
// the receiver cannot stall; busy stays high until the response is issued
module multi_timer_event_scheduler_core #(
   parameter int NUM_TIMERS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_timer_index,
   input  logic [30:0] req_arm_value,
   input  logic [31:0] req_compare_reg,
   input  logic [31:0] req_count_reg,
   input  logic [15:0] req_cycles,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_soonest_timer,
   output logic [31:0] rsp_countdown,
   output logic        rsp_none_active,
   output logic [2:0]  rsp_fired_source
);

   localparam int IDX_W = $clog2(NUM_TIMERS);

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [31:0]      ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [31:0]      ram_rd_data;
   mtes_pkg::rsp_type done;
   mtes_pkg::rsp_type rsp_ff;
   logic             rsp_strobe_ff;

   // timer offset store
   mtes_ram #(
      .WIDTH (32),
      .DEPTH (NUM_TIMERS)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // request sequencer and sweep datapath
   mtes_sched #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_sched (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_timer_index (req_timer_index),
      .req_arm_value   (req_arm_value),
      .req_compare_reg (req_compare_reg),
      .req_count_reg   (req_count_reg),
      .req_cycles      (req_cycles),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .done            (done)
   );

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done.valid;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_ff <= done;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_soonest_timer = rsp_ff.soonest_timer;
   assign rsp_countdown     = rsp_ff.countdown;
   assign rsp_none_active   = rsp_ff.none_active;
   assign rsp_fired_source  = rsp_ff.fired_source;

endmodule

/* rtl/core/mtes_checker.sv */
// mtes_checker: port-level checks on the scheduler top level, bound to it below
// depends only on the ports of multi_timer_event_scheduler_core
module mtes_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_soonest_timer,
   input logic        rsp_none_active,
   input logic [2:0]  rsp_fired_source
);

   // a taken transaction keeps the block busy or answers at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("transaction taken but neither busy nor answered");

   // the block is idle while a response is shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // leaving busy always issues the response
   assert property (@(posedge clock) disable iff (reset)
      (!busy && $past(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy ended without a response");

   // no selection reports timer zero, and sources stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((!rsp_none_active || rsp_soonest_timer == 3'd0)
                      && rsp_fired_source <= 3'd5))
      else $error("inconsistent response payload");

endmodule

bind multi_timer_event_scheduler_core mtes_checker u_mtes_checker (.*);

/* bench/timer_schedule_checker.sv */
// timer_schedule_checker: watches the request and response channels of the
// timer scheduler, predicts every response and compares it; depends on mtes_pkg
`timescale 1ns / 100ps

module timer_schedule_checker #(
   parameter int NUM_TIMERS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_timer_index,
   input  logic [30:0] req_arm_value,
   input  logic [31:0] req_compare_reg,
   input  logic [31:0] req_count_reg,
   input  logic [15:0] req_cycles,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_soonest_timer,
   input  logic [31:0] rsp_countdown,
   input  logic        rsp_none_active,
   input  logic [2:0]  rsp_fired_source,
   output int          mismatch_count,
   output int          outstanding
);

   localparam int unsigned NO_TIMER = 255;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [2:0]  soonest;
      logic [31:0] countdown;
      logic        none_active;
      logic [2:0]  fired;
   } sched_result_type;

   // predicted scheduler state
   logic [31:0] tmr_offset [NUM_TIMERS];
   logic        tmr_armed  [NUM_TIMERS];
   logic [31:0] countdown_now;
   int unsigned selected;

   sched_result_type expected_results [$];
   int errors = 0;
   int rsp_seen = 0;

   // compare slot parked at the far value is kept out of rebasing
   function automatic bit holds_far(int i);
      return i == mtes_pkg::TMR_COMPARE
             && tmr_offset[mtes_pkg::TMR_COMPARE] == mtes_pkg::FAR_SENTINEL;
   endfunction

   // rebase, pick the soonest timer, rebase back, with compare follow-ups
   function automatic void settle_schedule(logic [31:0] cmp, logic [31:0] cnt);
      logic [31:0] diff;
      for (int pass = 0; pass < 3; pass++) begin
         for (int i = 0; i < NUM_TIMERS; i++)
            if (tmr_armed[i] && !holds_far(i)) tmr_offset[i] += countdown_now;
         selected = NO_TIMER;
         countdown_now = mtes_pkg::FAR_SENTINEL;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tmr_armed[i] && $signed(tmr_offset[i]) < $signed(countdown_now)) begin
               countdown_now = tmr_offset[i];
               selected = i;
            end
         end
         for (int i = 0; i < NUM_TIMERS; i++)
            if (tmr_armed[i] && !holds_far(i)) tmr_offset[i] -= countdown_now;
         if (tmr_offset[mtes_pkg::TMR_COMPARE] != mtes_pkg::FAR_SENTINEL) return;
         diff = cmp - cnt;
         if (diff[31] || diff == mtes_pkg::FAR_SENTINEL) return;
         if (pass == mtes_pkg::LAST_PASS) return;
         if (diff == 32'd0) diff = mtes_pkg::ONE;
         tmr_offset[mtes_pkg::TMR_COMPARE] = diff - countdown_now;
         tmr_armed[mtes_pkg::TMR_COMPARE] = 1'b1;
      end
   endfunction

   // arm a timer, or disarm it on a zero value
   function automatic void load_timer(int unsigned idx, logic [31:0] value,
                                      logic [31:0] cmp, logic [31:0] cnt);
      if (idx >= NUM_TIMERS) return;
      if (value == 32'd0) begin
         tmr_offset[idx] = 32'd0;
         tmr_armed[idx] = 1'b0;
         return;
      end
      tmr_offset[idx] = value - countdown_now;
      tmr_armed[idx] = 1'b1;
      settle_schedule(cmp, cnt);
   endfunction

   // compare timer reload from compare minus count
   function automatic void reload_compare(logic [31:0] cmp, logic [31:0] cnt);
      logic [31:0] next;
      next = cmp - cnt;
      if (next[31]) next = mtes_pkg::FAR_SENTINEL;
      if (next == 32'd0) next = mtes_pkg::ONE;
      load_timer(mtes_pkg::TMR_COMPARE, next, cmp, cnt);
   endfunction

   // one transaction in, the response it should produce out
   function automatic sched_result_type schedule_request(
         logic [1:0] kind, logic [2:0] idx, logic [30:0] value,
         logic [31:0] cmp, logic [31:0] cnt, logic [15:0] cyc);
      sched_result_type res;
      longint remain;
      int unsigned who;
      logic [2:0] fired;
      fired = mtes_pkg::FIRED_NONE;
      case (kind)
         mtes_pkg::REQ_ARM: begin
            load_timer(32'(idx), {1'b0, value}, cmp, cnt);
         end
         mtes_pkg::REQ_REARM: begin
            reload_compare(cmp, cnt);
         end
         mtes_pkg::REQ_ADVANCE: begin
            remain = longint'($signed(countdown_now)) - longint'(cyc);
            if (remain < longint'($signed(mtes_pkg::MOST_NEG))) begin
               countdown_now = mtes_pkg::MOST_NEG;
            end else begin
               countdown_now = remain[31:0];
            end
            if (remain <= 0) begin
               who = selected;
               if (who == mtes_pkg::TMR_COMPARE) begin
                  fired = mtes_pkg::FIRED_COMPARE;
                  reload_compare(cmp, cnt);
               end else if (who == mtes_pkg::TMR_SI || who == mtes_pkg::TMR_PI
                            || who == mtes_pkg::TMR_RSP) begin
                  fired = 3'(who + 1);
                  load_timer(who, 32'd0, cmp, cnt);
               end else if (who == mtes_pkg::TMR_VI) begin
                  fired = mtes_pkg::FIRED_VI;
               end
               settle_schedule(cmp, cnt);
            end
         end
         default: begin
         end
      endcase
      res.soonest = (selected == NO_TIMER) ? 3'd0 : 3'(selected);
      res.countdown = countdown_now;
      res.none_active = (selected == NO_TIMER);
      res.fired = fired;
      return res;
   endfunction

   // response compare, then capture of a new transaction
   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            tmr_offset[i] = 32'd0;
            tmr_armed[i] = 1'b0;
         end
         countdown_now = mtes_pkg::FAR_SENTINEL;
         selected = NO_TIMER;
         expected_results.delete();
      end else begin
         if (rsp_strobe) begin
            rsp_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("response %0d with no transaction pending: timer %0d countdown %0d",
                           rsp_seen, rsp_soonest_timer, $signed(rsp_countdown));
            end else begin
               want = expected_results.pop_front();
               if (want.soonest !== rsp_soonest_timer || want.countdown !== rsp_countdown ||
                   want.none_active !== rsp_none_active || want.fired !== rsp_fired_source) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("response %0d: expected %0d %0d %0b %0d, actual %0d %0d %0b %0d",
                              rsp_seen, want.soonest, $signed(want.countdown),
                              want.none_active, want.fired, rsp_soonest_timer,
                              $signed(rsp_countdown), rsp_none_active, rsp_fired_source);
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(schedule_request(req_type, req_timer_index,
                                                        req_arm_value, req_compare_reg,
                                                        req_count_reg, req_cycles));
      end
      mismatch_count <= errors;
      outstanding <= expected_results.size();
   end

endmodule

/* bench/multi_timer_event_scheduler_core_tb.sv */
// multi_timer_event_scheduler_core_tb: drives directed, back-to-back and random
// transactions into the scheduler; depends on mtes_pkg and timer_schedule_checker
`timescale 1ns / 100ps

module multi_timer_event_scheduler_core_tb;

   localparam int NUM_TIMERS = 5;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_EVERY = 300;
   localparam int SETTLE_CYCLES = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = mtes_pkg::REQ_ARM;
   logic [2:0]  req_timer_index = 3'd0;
   logic [30:0] req_arm_value = 31'd0;
   logic [31:0] req_compare_reg = 32'd0;
   logic [31:0] req_count_reg = 32'd0;
   logic [15:0] req_cycles = 16'd0;
   logic        rsp_strobe;
   logic [2:0]  rsp_soonest_timer;
   logic [31:0] rsp_countdown;
   logic        rsp_none_active;
   logic [2:0]  rsp_fired_source;

   int mismatch_count;
   int outstanding;
   int idle_pct = 20;

   multi_timer_event_scheduler_core #(
      .NUM_TIMERS(NUM_TIMERS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_timer_index(req_timer_index),
      .req_arm_value(req_arm_value),
      .req_compare_reg(req_compare_reg),
      .req_count_reg(req_count_reg),
      .req_cycles(req_cycles),
      .rsp_strobe(rsp_strobe),
      .rsp_soonest_timer(rsp_soonest_timer),
      .rsp_countdown(rsp_countdown),
      .rsp_none_active(rsp_none_active),
      .rsp_fired_source(rsp_fired_source)
   );

   timer_schedule_checker #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_timer_index(req_timer_index),
      .req_arm_value(req_arm_value),
      .req_compare_reg(req_compare_reg),
      .req_count_reg(req_count_reg),
      .req_cycles(req_cycles),
      .rsp_strobe(rsp_strobe),
      .rsp_soonest_timer(rsp_soonest_timer),
      .rsp_countdown(rsp_countdown),
      .rsp_none_active(rsp_none_active),
      .rsp_fired_source(rsp_fired_source),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // random gaps before a transaction, now and then a long one
   task automatic idle_gap();
      if (idle_pct == 0) return;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      if ($urandom_range(39) == 0) begin
         repeat ($urandom_range(90, 1)) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // present one transaction and hold it until accepted
   task automatic send_request(input logic [1:0] kind, input logic [2:0] idx,
                               input logic [30:0] value, input logic [31:0] cmp,
                               input logic [31:0] cnt, input logic [15:0] cyc);
      idle_gap();
      start <= 1'b1;
      req_type <= kind;
      req_timer_index <= idx;
      req_arm_value <= value;
      req_compare_reg <= cmp;
      req_count_reg <= cnt;
      req_cycles <= cyc;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // hold off until every response is back
   task automatic drain_results();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
   endtask

   // compare and count pair with a chosen kind of difference
   task automatic pick_regs(output logic [31:0] cmp, output logic [31:0] cnt);
      logic [31:0] diff;
      int roll;
      roll = $urandom_range(9);
      cnt = $urandom;
      case (roll)
         0: diff = 32'd0;
         1: diff = mtes_pkg::FAR_SENTINEL;
         2, 3: diff = $urandom | mtes_pkg::MOST_NEG;
         4: diff = $urandom;
         default: diff = $urandom_range(100000, 1);
      endcase
      cmp = cnt + diff;
   endtask

   // one random transaction, weighted toward arms and advances
   task automatic random_request();
      logic [1:0]  kind;
      logic [2:0]  idx;
      logic [30:0] value;
      logic [31:0] cmp;
      logic [31:0] cnt;
      logic [15:0] cyc;
      int roll;
      roll = $urandom_range(99);
      idx = 3'($urandom);
      value = 31'($urandom);
      cyc = 16'($urandom);
      pick_regs(cmp, cnt);
      if (roll < 45) begin
         kind = mtes_pkg::REQ_ARM;
         idx = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         case ($urandom_range(9))
            0: value = 31'd0;
            1: value = 31'($urandom);
            2: value = mtes_pkg::FAR_SENTINEL[30:0];
            default: value = 31'($urandom_range(70000, 1));
         endcase
      end else if (roll < 65) begin
         kind = mtes_pkg::REQ_REARM;
      end else if (roll < 95) begin
         kind = mtes_pkg::REQ_ADVANCE;
         case ($urandom_range(9))
            0: cyc = 16'd0;
            1: cyc = 16'hFFFF;
            2, 3, 4, 5: cyc = 16'($urandom);
            default: cyc = 16'($urandom_range(3000, 1));
         endcase
      end else begin
         kind = REQ_UNKNOWN;
      end
      send_request(kind, idx, value, cmp, cnt, cyc);
   endtask

   // stimulus and verdict
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, each timer, ignored slots, compare edge cases
      send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd0, 32'd0, 16'd0);
      send_request(mtes_pkg::REQ_ADVANCE, 3'd7, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                   16'hFFFF);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_SI), 31'd100, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_PI), 31'd50, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_VI), 31'h7FFF_FFFF, 32'd0, 32'd1,
                   16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_RSP), 31'd1, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'd5, 31'd10, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'd7, 31'h7FFF_FFFF, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_RSP), 31'd0, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_REARM, 3'd0, 31'd0, 32'd1000, 32'd800, 16'd0);
      send_request(mtes_pkg::REQ_REARM, 3'd0, 31'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
      send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd300, 32'd0, 16'd1);
      send_request(mtes_pkg::REQ_REARM, 3'd0, 31'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd0);
      send_request(mtes_pkg::REQ_REARM, 3'd0, 31'd0, 32'h7FFF_FFFF, 32'd0, 16'd0);
      send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd40, 32'd0, 16'hFFFF);
      send_request(mtes_pkg::REQ_REARM, 3'd0, 31'd0, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_SI), 31'd16, 32'h1234_5678,
                   32'h1234_5678, 16'd0);
      send_request(REQ_UNKNOWN, 3'd7, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_RSP), 31'd20, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd0, 32'd1, 16'hFFFF);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_VI), 31'd5, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd0, 32'd1, 16'hFFFF);
      send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd0, 32'd1, 16'd0);
      drain_results();

      // back to back: clear the table, park vi at the far value, advance it
      idle_pct = 0;
      for (int i = 0; i < NUM_TIMERS; i++)
         send_request(mtes_pkg::REQ_ARM, 3'(i), 31'd0, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_VI), 31'h7FFF_FFFF, 32'd0, 32'd1,
                   16'd0);
      repeat (8) send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd0, 32'd1, 16'hFFFF);
      send_request(mtes_pkg::REQ_ADVANCE, 3'd0, 31'd0, 32'd0, 32'd1, 16'd0);
      send_request(mtes_pkg::REQ_ARM, 3'(mtes_pkg::TMR_VI), 31'd0, 32'd0, 32'd1, 16'd0);
      drain_results();

      // random transactions, with an idle-free stretch and periodic drains
      idle_pct = 20;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_pct = (n >= 600 && n < 900) ? 0 : 20;
         if (n > 0 && n % DRAIN_EVERY == 0) drain_results();
         random_request();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
